// ----- hdl/urdf_pkg.sv -----
// Shared types, constants and the CRC8 byte update for the UART register datagram framer.
// No dependencies; every other file of the block depends on this package.
package urdf_pkg;

    // Field widths.
    localparam int BYTE_W   = 8;
    localparam int REQ_W    = 2;
    localparam int ADDR_W   = 7;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int IDX_W    = 3;

    // Default depth of the command queue between front and back.
    localparam int QUEUE_DEPTH_DEF = 2;

    // Datagram constants.
    localparam logic [BYTE_W-1:0] SYNC_BYTE   = 8'h05;
    localparam logic [BYTE_W-1:0] HOST_ADDR   = 8'hff;
    localparam logic [BYTE_W-1:0] CRC_POLY    = 8'h07;

    // Byte positions inside a datagram.
    localparam logic [IDX_W-1:0] IDX_SYNC  = 3'd0;
    localparam logic [IDX_W-1:0] IDX_NODE  = 3'd1;
    localparam logic [IDX_W-1:0] IDX_REG   = 3'd2;
    localparam logic [IDX_W-1:0] IDX_VAL3  = 3'd3;
    localparam logic [IDX_W-1:0] IDX_VAL2  = 3'd4;
    localparam logic [IDX_W-1:0] IDX_VAL1  = 3'd5;
    localparam logic [IDX_W-1:0] IDX_VAL0  = 3'd6;
    localparam logic [IDX_W-1:0] IDX_LAST  = 3'd7;
    localparam logic [IDX_W-1:0] IDX_RD_CRC = 3'd3;

    // Input request codes.
    typedef enum logic [REQ_W-1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_REPLY = 2'd2
    } req_type_t;

    // Result kinds.
    localparam logic KIND_TX   = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // Read completion status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_CRC_ERR = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_HDR_ERR = 2'd2;

    // Commands handed from the front to the back.
    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_DONE  = 2'd2
    } cmd_kind_t;

    // One queue entry. The value carries the write data or the read result.
    typedef struct packed {
        cmd_kind_t            kind;
        logic [BYTE_W-1:0]    node;
        logic [ADDR_W-1:0]    reg_num;
        logic [VALUE_W-1:0]   value;
        logic [STATUS_W-1:0]  status;
    } cmd_t;

    // CRC8, polynomial 0x07, one byte fed least significant bit first.
    function automatic logic [BYTE_W-1:0] crc8_feed(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
        logic [BYTE_W-1:0] c;
        logic              fb;
        c = crc;
        for (int i = 0; i < BYTE_W; i++)
        begin
            fb = c[BYTE_W-1] ^ data[i];
            c  = {c[BYTE_W-2:0], 1'b0};
            if (fb)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

// ----- hdl/urdf_if.sv -----
// Valid/ready channel interfaces for the request and result words of the framer.
// Depends on urdf_pkg for the field widths.

interface urdf_req_if;
    logic                          valid;
    logic                          ready;
    logic [urdf_pkg::REQ_W-1:0]    req_type;
    logic [urdf_pkg::ADDR_W-1:0]   reg_num;
    logic [urdf_pkg::VALUE_W-1:0]  write_value;
    logic [urdf_pkg::BYTE_W-1:0]   rx_byte;

    modport source (output valid, req_type, reg_num, write_value, rx_byte, input ready);
    modport sink   (input valid, req_type, reg_num, write_value, rx_byte, output ready);
endinterface

interface urdf_res_if;
    logic                          valid;
    logic                          ready;
    logic                          result_kind;
    logic [urdf_pkg::BYTE_W-1:0]   tx_byte;
    logic                          last_of_run;
    logic [urdf_pkg::VALUE_W-1:0]  read_value;
    logic [urdf_pkg::STATUS_W-1:0] read_status;

    modport source (output valid, result_kind, tx_byte, last_of_run, read_value, read_status,
                    input ready);
    modport sink   (input valid, result_kind, tx_byte, last_of_run, read_value, read_status,
                    output ready);
endinterface

// ----- hdl/urdf_front.sv -----
// Front part: accepts request words, keeps the node address and the reply collector,
// and pushes transmit and completion commands into the queue. Depends on urdf_pkg, urdf_if.
module urdf_front (
    input  logic                       clk,
    input  logic                       rst_n,
    urdf_req_if.sink                   req,
    input  logic                       cfg_wr_en,
    input  logic [urdf_pkg::BYTE_W-1:0] cfg_wr_data,
    input  logic                       queue_space,
    output logic                       push_valid,
    output urdf_pkg::cmd_t             push_cmd
);
    import urdf_pkg::*;

    logic [BYTE_W-1:0]   node_address_reg;
    logic [ADDR_W-1:0]   expected_reg_reg,  expected_reg_next;
    logic [IDX_W-1:0]    reply_count_reg,   reply_count_next;
    logic [BYTE_W-1:0]   reply_crc_reg,     reply_crc_next;
    logic [VALUE_W-1:0]  reply_shift_reg,   reply_shift_next;
    logic                reply_hdr_ok_reg,  reply_hdr_ok_next;

    logic                accept;
    logic [BYTE_W-1:0]   crc_base;
    logic [STATUS_W-1:0] done_status;

    assign req.ready = queue_space;
    assign accept    = req.valid && req.ready;

    // The first reply byte restarts the CRC from zero.
    assign crc_base = (reply_count_reg == IDX_SYNC) ? '0 : reply_crc_reg;

    // A CRC mismatch wins over a header mismatch.
    always_comb
    begin
        if (req.rx_byte != reply_crc_reg)
        begin
            done_status = STATUS_CRC_ERR;
        end
        else if (!reply_hdr_ok_reg)
        begin
            done_status = STATUS_HDR_ERR;
        end
        else
        begin
            done_status = STATUS_OK;
        end
    end

    // Classify the accepted word and update the reply collector.
    always_comb
    begin
        expected_reg_next  = expected_reg_reg;
        reply_count_next   = reply_count_reg;
        reply_crc_next     = reply_crc_reg;
        reply_shift_next   = reply_shift_reg;
        reply_hdr_ok_next  = reply_hdr_ok_reg;
        push_valid         = 1'b0;
        push_cmd.kind      = CMD_READ;
        push_cmd.node      = node_address_reg;
        push_cmd.reg_num   = req.reg_num;
        push_cmd.value     = '0;
        push_cmd.status    = STATUS_OK;

        if (accept)
        begin
            unique case (req.req_type)
                REQ_READ:
                begin
                    push_valid        = 1'b1;
                    push_cmd.kind     = CMD_READ;
                    expected_reg_next = req.reg_num;
                    reply_count_next  = '0;
                    reply_crc_next    = '0;
                    reply_shift_next  = '0;
                    reply_hdr_ok_next = 1'b0;
                end
                REQ_WRITE:
                begin
                    push_valid     = 1'b1;
                    push_cmd.kind  = CMD_WRITE;
                    push_cmd.value = req.write_value;
                end
                REQ_REPLY:
                begin
                    if (reply_count_reg == IDX_LAST)
                    begin
                        push_valid        = 1'b1;
                        push_cmd.kind     = CMD_DONE;
                        push_cmd.status   = done_status;
                        push_cmd.value    = (done_status == STATUS_OK) ? reply_shift_reg : '0;
                        reply_count_next  = '0;
                        reply_crc_next    = '0;
                        reply_shift_next  = '0;
                        reply_hdr_ok_next = 1'b0;
                    end
                    else
                    begin
                        reply_crc_next   = crc8_feed(crc_base, req.rx_byte);
                        reply_count_next = reply_count_reg + 1'b1;
                        unique case (reply_count_reg)
                            IDX_SYNC:
                            begin
                                reply_shift_next  = '0;
                                reply_hdr_ok_next = 1'b1;
                            end
                            IDX_NODE:
                            begin
                                if (req.rx_byte != HOST_ADDR)
                                begin
                                    reply_hdr_ok_next = 1'b0;
                                end
                            end
                            IDX_REG:
                            begin
                                if (req.rx_byte[ADDR_W-1:0] != expected_reg_reg)
                                begin
                                    reply_hdr_ok_next = 1'b0;
                                end
                            end
                            default:
                            begin
                                reply_shift_next = {reply_shift_reg[VALUE_W-BYTE_W-1:0],
                                                    req.rx_byte};
                            end
                        endcase
                    end
                end
                default:
                begin
                    push_valid = 1'b0;
                end
            endcase
        end
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_address_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            node_address_reg <= cfg_wr_data;
        end
    end

    // Reply collector state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reg_reg <= '0;
            reply_count_reg  <= '0;
            reply_crc_reg    <= '0;
            reply_shift_reg  <= '0;
            reply_hdr_ok_reg <= 1'b0;
        end
        else
        begin
            expected_reg_reg <= expected_reg_next;
            reply_count_reg  <= reply_count_next;
            reply_crc_reg    <= reply_crc_next;
            reply_shift_reg  <= reply_shift_next;
            reply_hdr_ok_reg <= reply_hdr_ok_next;
        end
    end

endmodule

// ----- hdl/urdf_queue.sv -----
// Small command queue between front and back, built from registers.
// Depends on urdf_pkg for the command type.
module urdf_queue #(
    parameter int DEPTH = urdf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    input  urdf_pkg::cmd_t  push_cmd,
    output logic            space,
    output logic            head_valid,
    output urdf_pkg::cmd_t  head_cmd,
    input  logic            pop
);
    import urdf_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t              entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg,  count_next;
    logic              do_push;
    logic              do_pop;

    assign space      = (count_reg != CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && space;
    assign do_pop     = pop && head_valid;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- hdl/urdf_back.sv -----
// Back part: expands queued commands into datagram bytes or a completion word, one per
// cycle while the result receiver is ready, computing the request CRC on the way. Depends on urdf_pkg and urdf_if.
module urdf_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  urdf_pkg::cmd_t  head_cmd,
    output logic            pop,
    urdf_res_if.source      res
);
    import urdf_pkg::*;

    logic [IDX_W-1:0]    idx_reg,   idx_next;
    logic [BYTE_W-1:0]   crc_reg,   crc_next;
    logic                out_valid_reg;
    logic                out_kind_reg;
    logic [BYTE_W-1:0]   out_byte_reg;
    logic                out_last_reg;
    logic [VALUE_W-1:0]  out_value_reg;
    logic [STATUS_W-1:0] out_status_reg;

    logic                load;
    logic                is_write;
    logic                is_done;
    logic                is_last;
    logic [BYTE_W-1:0]   cur_byte;

    assign load     = head_valid && (!out_valid_reg || res.ready);
    assign is_write = (head_cmd.kind == CMD_WRITE);
    assign is_done  = (head_cmd.kind == CMD_DONE);
    assign is_last  = is_done || (idx_reg == (is_write ? IDX_LAST : IDX_RD_CRC));
    assign pop      = load && is_last;

    // Datagram byte at the current position; the final byte is the running CRC.
    always_comb
    begin
        unique case (idx_reg)
            IDX_SYNC: cur_byte = SYNC_BYTE;
            IDX_NODE: cur_byte = head_cmd.node;
            IDX_REG:  cur_byte = {is_write, head_cmd.reg_num};
            IDX_VAL3: cur_byte = is_write ? head_cmd.value[31:24] : crc_reg;
            IDX_VAL2: cur_byte = head_cmd.value[23:16];
            IDX_VAL1: cur_byte = head_cmd.value[15:8];
            IDX_VAL0: cur_byte = head_cmd.value[7:0];
            default:  cur_byte = crc_reg;
        endcase
    end

    // Byte position and CRC advance.
    always_comb
    begin
        idx_next = idx_reg;
        crc_next = crc_reg;
        if (load)
        begin
            if (is_last)
            begin
                idx_next = '0;
                crc_next = '0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
                crc_next = crc8_feed(crc_reg, cur_byte);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            crc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            crc_reg <= crc_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output word register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_kind_reg   <= is_done ? KIND_DONE : KIND_TX;
            out_byte_reg   <= is_done ? '0 : cur_byte;
            out_last_reg   <= is_last;
            out_value_reg  <= is_done ? head_cmd.value : '0;
            out_status_reg <= is_done ? head_cmd.status : STATUS_OK;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.result_kind = out_kind_reg;
    assign res.tx_byte     = out_byte_reg;
    assign res.last_of_run = out_last_reg;
    assign res.read_value  = out_value_reg;
    assign res.read_status = out_status_reg;

endmodule

// ----- hdl/uart_register_datagram_framer.sv -----
// UART register datagram framer. The first result word of a request passes through the command
// queue and the output register; the back emits one result word per cycle while the receiver
// is ready, so a write gives 8 words, a read 4 and a completion 1, and the front takes a word
// each cycle while the command queue has room. Reply bytes that complete nothing emit no word.
// Reset (rst_n low, asynchronous) empties queue and output, clears the reply collector,
// the expected register and the node address.
module uart_register_datagram_framer #(
    parameter int QUEUE_DEPTH = urdf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    urdf_req_if.sink                    req,
    urdf_res_if.source                  res,
    input  logic                        cfg_wr_en,
    input  logic [urdf_pkg::BYTE_W-1:0] cfg_wr_data
);
    import urdf_pkg::*;

    logic  queue_space;
    logic  push_valid;
    cmd_t  push_cmd;
    logic  head_valid;
    cmd_t  head_cmd;
    logic  pop;

    // Request classification and reply collection.
    urdf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .queue_space (queue_space),
        .push_valid  (push_valid),
        .push_cmd    (push_cmd)
    );

    // Command queue.
    urdf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .space      (queue_space),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop)
    );

    // Byte serializer and result register.
    urdf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .res        (res)
    );

endmodule

// ----- dv/tb_uart_register_datagram_framer.sv -----
// Self-checking testbench for the UART register datagram framer: a short table of requests and
// reply bytes, then random read/reply transactions, writes and noise under several node addresses.
// Depends on urdf_pkg and the channel interfaces in urdf_if; needs nothing else but the RTL.
module tb_uart_register_datagram_framer;
    timeunit 1ns;
    timeprecision 1ps;

    import urdf_pkg::*;

    // Request code the block must ignore.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    // Receiver hold-off used to fill the block and stall its input.
    localparam int HOLD_CYCLES = 150;
    // Cycles to let a reply byte with no result settle before a register write.
    localparam int SETTLE_CYCLES = 8;

    // One result word as the framer should emit it.
    typedef struct {
        logic                kind;
        logic [BYTE_W-1:0]   tx;
        logic                last;
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
    } out_word_t;

    // One row of the directed table. A row with use_crc sends the running reply CRC as its
    // byte; a row with typed carries the completion that it must produce.
    typedef struct {
        logic [REQ_W-1:0]    rtype;
        logic [ADDR_W-1:0]   reg_a;
        logic [VALUE_W-1:0]  wval;
        logic [BYTE_W-1:0]   rx;
        bit                  use_crc;
        bit                  typed;
        logic [STATUS_W-1:0] t_status;
        logic [VALUE_W-1:0]  t_value;
    } dir_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [BYTE_W-1:0]   cfg_wr_data;

    urdf_req_if req_ch ();
    urdf_res_if res_ch ();

    uart_register_datagram_framer uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .res         (res_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Mirror of the framer: node address, latched register and the reply collector.
    logic [BYTE_W-1:0]   node_addr_cfg;
    logic [ADDR_W-1:0]   want_reg;
    logic [IDX_W-1:0]    rx_count;
    logic [BYTE_W-1:0]   rx_crc;
    logic [VALUE_W-1:0]  rx_value;
    logic                rx_hdr_good;

    out_word_t words_due[$];
    int        fails = 0;
    int        words_sent = 0;
    bit        quiet = 1'b0;
    bit        hold_pending = 1'b0;

    // Read errors first, then writes, partial reply dropped by a read, then a good reply.
    dir_row_t dir_tab [0:22] = '{
        '{REQ_READ,   7'h00, 32'h0000_0000, 8'h00, 1'b0, 1'b0, STATUS_OK,      32'h0},
        '{REQ_REPLY,  7'h00, 32'h0000_0000, 8'h00, 1'b0, 1'b0, STATUS_OK,      32'h0},
        '{REQ_REPLY,  7'h00, 32'h0000_0000, 8'h00, 1'b0, 1'b0, STATUS_OK,      32'h0},
        '{REQ_REPLY,  7'h00, 32'h0000_0000, 8'h00, 1'b0, 1'b0, STATUS_OK,      32'h0},
        '{REQ_REPLY,  7'h00, 32'h0000_0000, 8'h00, 1'b0, 1'b0, STATUS_OK,      32'h0},
        '{REQ_REPLY,  7'h00, 32'h0000_0000, 8'h00, 1'b0, 1'b0, STATUS_OK,      32'h0},
        '{REQ_REPLY,  7'h00, 32'h0000_0000, 8'h00, 1'b0, 1'b0, STATUS_OK,      32'h0},
        '{REQ_REPLY,  7'h00, 32'h0000_0000, 8'h00, 1'b0, 1'b0, STATUS_OK,      32'h0},
        '{REQ_REPLY,  7'h00, 32'h0000_0000, 8'h01, 1'b0, 1'b1, STATUS_CRC_ERR, 32'h0},
        '{REQ_WRITE,  7'h7f, 32'hffff_ffff, 8'hff, 1'b0, 1'b0, STATUS_OK,      32'h0},
        '{REQ_WRITE,  7'h00, 32'h0000_0000, 8'h00, 1'b0, 1'b0, STATUS_OK,      32'h0},
        '{REQ_UNUSED, 7'h55, 32'ha5a5_a5a5, 8'haa, 1'b0, 1'b0, STATUS_OK,      32'h0},
        '{REQ_REPLY,  7'h00, 32'h0000_0000, 8'h05, 1'b0, 1'b0, STATUS_OK,      32'h0},
        '{REQ_REPLY,  7'h00, 32'h0000_0000, 8'hff, 1'b0, 1'b0, STATUS_OK,      32'h0},
        '{REQ_READ,   7'h7f, 32'h5a5a_5a5a, 8'h55, 1'b0, 1'b0, STATUS_OK,      32'h0},
        '{REQ_REPLY,  7'h00, 32'h0000_0000, 8'h05, 1'b0, 1'b0, STATUS_OK,      32'h0},
        '{REQ_REPLY,  7'h00, 32'h0000_0000, 8'hff, 1'b0, 1'b0, STATUS_OK,      32'h0},
        '{REQ_REPLY,  7'h00, 32'h0000_0000, 8'hff, 1'b0, 1'b0, STATUS_OK,      32'h0},
        '{REQ_REPLY,  7'h00, 32'h0000_0000, 8'hde, 1'b0, 1'b0, STATUS_OK,      32'h0},
        '{REQ_REPLY,  7'h00, 32'h0000_0000, 8'had, 1'b0, 1'b0, STATUS_OK,      32'h0},
        '{REQ_REPLY,  7'h00, 32'h0000_0000, 8'hbe, 1'b0, 1'b0, STATUS_OK,      32'h0},
        '{REQ_REPLY,  7'h00, 32'h0000_0000, 8'hef, 1'b0, 1'b0, STATUS_OK,      32'h0},
        '{REQ_REPLY,  7'h00, 32'h0000_0000, 8'h00, 1'b1, 1'b0, STATUS_OK,      32'h0}
    };

    // Clock, 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit, far beyond the slowest correct run.
    initial
    begin
        #300000;
        $display("== FAIL ==");
        $finish;
    end

    // CRC8 with polynomial 0x07, data bits taken least significant first.
    function automatic logic [BYTE_W-1:0] crc_lsb_first(input logic [BYTE_W-1:0] acc,
                                                        input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] c;
        c = acc;
        for (int k = 0; k < BYTE_W; k++)
        begin
            if (c[BYTE_W-1] ^ b[k])
                c = (c << 1) ^ CRC_POLY;
            else
                c = c << 1;
        end
        return c;
    endfunction

    // Advance the mirror by one accepted word and queue the words it must produce.
    // A typed completion replaces the computed value and status.
    task automatic advance_framer(input logic [REQ_W-1:0] rt, input logic [ADDR_W-1:0] ra,
                                  input logic [VALUE_W-1:0] wv, input logic [BYTE_W-1:0] rx,
                                  input bit typed, input logic [STATUS_W-1:0] ts,
                                  input logic [VALUE_W-1:0] tv);
        logic [BYTE_W-1:0]   bytes [0:7];
        logic [BYTE_W-1:0]   crc;
        logic [STATUS_W-1:0] st;
        logic [VALUE_W-1:0]  val;
        int                  n;
        case (rt)
            REQ_READ, REQ_WRITE:
            begin
                bytes[0] = SYNC_BYTE;
                bytes[1] = node_addr_cfg;
                bytes[2] = {rt == REQ_WRITE, ra};
                if (rt == REQ_WRITE)
                begin
                    bytes[3] = wv[31:24];
                    bytes[4] = wv[23:16];
                    bytes[5] = wv[15:8];
                    bytes[6] = wv[7:0];
                    n = 8;
                end
                else
                begin
                    // A read drops whatever partial reply was collected.
                    n = 4;
                    want_reg    = ra;
                    rx_count    = '0;
                    rx_crc      = '0;
                    rx_value    = '0;
                    rx_hdr_good = 1'b0;
                end
                crc = '0;
                for (int i = 0; i < n - 1; i++)
                    crc = crc_lsb_first(crc, bytes[i]);
                bytes[n-1] = crc;
                for (int i = 0; i < n; i++)
                    words_due.push_back('{KIND_TX, bytes[i], i == n - 1, '0, STATUS_OK});
            end
            REQ_REPLY:
            begin
                if (rx_count == IDX_LAST)
                begin
                    // CRC failure outranks a header failure; any error zeroes the value.
                    st  = STATUS_OK;
                    val = rx_value;
                    if (rx != rx_crc)
                        st = STATUS_CRC_ERR;
                    else if (!rx_hdr_good)
                        st = STATUS_HDR_ERR;
                    if (st != STATUS_OK)
                        val = '0;
                    if (typed)
                    begin
                        st  = ts;
                        val = tv;
                    end
                    words_due.push_back('{KIND_DONE, '0, 1'b1, val, st});
                    rx_count    = '0;
                    rx_crc      = '0;
                    rx_value    = '0;
                    rx_hdr_good = 1'b0;
                end
                else
                begin
                    if (rx_count == IDX_SYNC)
                    begin
                        rx_crc      = '0;
                        rx_value    = '0;
                        rx_hdr_good = 1'b1;
                    end
                    else if (rx_count == IDX_NODE)
                    begin
                        if (rx != HOST_ADDR)
                            rx_hdr_good = 1'b0;
                    end
                    else if (rx_count == IDX_REG)
                    begin
                        if (rx[ADDR_W-1:0] != want_reg)
                            rx_hdr_good = 1'b0;
                    end
                    else
                    begin
                        rx_value = {rx_value[VALUE_W-9:0], rx};
                    end
                    rx_crc   = crc_lsb_first(rx_crc, rx);
                    rx_count = rx_count + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Offer one request word, idling at random first, and mirror it once accepted.
    task automatic put_word(input logic [REQ_W-1:0] rt, input logic [ADDR_W-1:0] ra,
                            input logic [VALUE_W-1:0] wv, input logic [BYTE_W-1:0] rx,
                            input bit typed = 1'b0,
                            input logic [STATUS_W-1:0] ts = STATUS_OK,
                            input logic [VALUE_W-1:0] tv = '0);
        while (!quiet && $urandom_range(99) < 36)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= rt;
        req_ch.reg_num     <= ra;
        req_ch.write_value <= wv;
        req_ch.rx_byte     <= rx;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        words_sent++;
        advance_framer(rt, ra, wv, rx, typed, ts, tv);
    endtask

    // A read request followed by its reply, well formed or flawed, sometimes cut short.
    task automatic run_read_reply(input logic [ADDR_W-1:0] ra);
        logic [BYTE_W-1:0]  rb [0:7];
        logic [VALUE_W-1:0] v;
        logic [BYTE_W-1:0]  c;
        int                 cut;
        put_word(REQ_READ, ra, $urandom, 8'($urandom_range(255)));
        v = $urandom;
        rb[0] = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : SYNC_BYTE;
        rb[1] = HOST_ADDR;
        rb[2] = {1'($urandom_range(1)), ra};
        rb[3] = v[31:24];
        rb[4] = v[23:16];
        rb[5] = v[15:8];
        rb[6] = v[7:0];
        c = '0;
        for (int k = 0; k < 7; k++)
            c = crc_lsb_first(c, rb[k]);
        rb[7] = c;
        case ($urandom_range(7))
            0: rb[1] = rb[1] ^ 8'($urandom_range(1, 255));
            1: rb[2][ADDR_W-1:0] = rb[2][ADDR_W-1:0] ^ 7'($urandom_range(1, 127));
            2: rb[7] = rb[7] ^ 8'($urandom_range(1, 255));
            3: rb[4] = rb[4] ^ 8'($urandom_range(1, 255));
            default:
            begin
            end
        endcase
        cut = ($urandom_range(9) == 0) ? $urandom_range(1, 7) : 8;
        for (int k = 0; k < cut; k++)
            put_word(REQ_REPLY, 7'($urandom_range(127)), $urandom, rb[k]);
    endtask

    // Random mix of transactions until the given number of words has gone in.
    task automatic random_phase(input int budget);
        int          start;
        int          pick;
        logic [31:0] wv;
        start = words_sent;
        while (words_sent - start < budget)
        begin
            pick = $urandom_range(99);
            case ($urandom_range(3))
                0: wv = '0;
                1: wv = '1;
                default: wv = $urandom;
            endcase
            if (pick < 50)
                run_read_reply(7'($urandom_range(127)));
            else if (pick < 70)
                put_word(REQ_WRITE, 7'($urandom_range(127)), wv, 8'($urandom_range(255)));
            else if (pick < 80)
            begin
                // Stray reply bytes with no read in front of them.
                repeat ($urandom_range(1, 3))
                    put_word(REQ_REPLY, 7'($urandom_range(127)), $urandom,
                             8'($urandom_range(255)));
            end
            else if (pick < 88)
                put_word(REQ_READ, 7'($urandom_range(127)), wv, 8'($urandom_range(255)));
            else
                put_word(REQ_UNUSED, 7'($urandom_range(127)), wv, 8'($urandom_range(255)));
        end
    endtask

    // Stop offering, wait for every word due, then let a silent reply byte finish.
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (words_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the node address register while the block is idle.
    task automatic write_node(input logic [BYTE_W-1:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        node_addr_cfg = v;
    endtask

    // Result receiver: random stalls, one long hold-off on request.
    initial
    begin
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            res_ch.ready <= quiet || ($urandom_range(99) >= 36);
        end
    end

    // Compare each accepted result word with the oldest one due.
    always @(posedge clk)
    begin : check_words
        out_word_t w;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (words_due.size() == 0)
            begin
                $error("result word with none due: kind %0d tx %h", res_ch.result_kind,
                       res_ch.tx_byte);
                fails++;
            end
            else
            begin
                w = words_due.pop_front();
                if (res_ch.result_kind !== w.kind)
                begin
                    $error("result_kind: expected %0d, got %0d", w.kind, res_ch.result_kind);
                    fails++;
                end
                if (res_ch.tx_byte !== w.tx)
                begin
                    $error("tx_byte: expected %h, got %h", w.tx, res_ch.tx_byte);
                    fails++;
                end
                if (res_ch.last_of_run !== w.last)
                begin
                    $error("last_of_run: expected %0d, got %0d", w.last, res_ch.last_of_run);
                    fails++;
                end
                if (res_ch.read_value !== w.value)
                begin
                    $error("read_value: expected %h, got %h", w.value, res_ch.read_value);
                    fails++;
                end
                if (res_ch.read_status !== w.status)
                begin
                    $error("read_status: expected %0d, got %0d", w.status, res_ch.read_status);
                    fails++;
                end
            end
        end
    end

    // Reset, directed table, then random phases under several node addresses.
    initial
    begin
        logic [BYTE_W-1:0] rx;
        rst_n              <= 1'b0;
        cfg_wr_en          <= 1'b0;
        cfg_wr_data        <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= REQ_READ;
        req_ch.reg_num     <= '0;
        req_ch.write_value <= '0;
        req_ch.rx_byte     <= '0;
        node_addr_cfg = '0;
        want_reg      = '0;
        rx_count      = '0;
        rx_crc        = '0;
        rx_value      = '0;
        rx_hdr_good   = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows run with the node address still at its reset value.
        foreach (dir_tab[i])
        begin
            rx = dir_tab[i].use_crc ? rx_crc : dir_tab[i].rx;
            put_word(dir_tab[i].rtype, dir_tab[i].reg_a, dir_tab[i].wval, rx,
                     dir_tab[i].typed, dir_tab[i].t_status, dir_tab[i].t_value);
        end
        settle();

        // Top address, with the receiver holding off long enough to stall the input.
        write_node(8'hff);
        hold_pending = 1'b1;
        random_phase(22);
        settle();

        // Bottom address, with neither side idling.
        write_node(8'h00);
        quiet = 1'b1;
        random_phase(20);
        quiet = 1'b0;
        settle();

        write_node(8'($urandom_range(1, 254)));
        random_phase(20);
        settle();

        write_node(8'h5a);
        random_phase(15);
        settle();

        if (fails == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/urdf_pkg.sv
hdl/urdf_if.sv
hdl/urdf_front.sv
hdl/urdf_queue.sv
hdl/urdf_back.sv
hdl/uart_register_datagram_framer.sv
dv/tb_uart_register_datagram_framer.sv
